@@ design/xcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared constants and types of the framed receiver: frame markers, length
// limits, register map and the status bundle of the frame parser.
// ----------------------------------------------------------------------------
package xcfr_pkg;

	localparam logic [7:0] START_MARK      = 8'hAA;
	localparam logic [7:0] HANDSHAKE_KIND  = 8'h01;
	localparam logic [7:0] MIN_FRAME_BYTES = 8'd4;
	localparam int         MAX_FRAME_DEF   = 64;

	localparam logic [7:0] BOARD_ID_RESET  = 8'h01;

	// register map: byte address 4*i, index taken from paddr[2]
	localparam int         CFG_ADDR_W      = 3;
	localparam logic       REG_BOARD_ID    = 1'b0;

	// reply beats outstanding: up to two replies of two beats each
	localparam int         PEND_W          = 3;
	localparam int         REPLY_BEATS     = 2;
	localparam int         PEND_MAX        = 4;

	typedef struct packed {
		logic reply;    // this byte closes a good handshake frame
		logic link_up;  // sticky connected flag
	} xcfr_status_t;

endpackage

@@ design/xcfr_if.sv @@
// ----------------------------------------------------------------------------
// xcfr_rx_if / xcfr_tx_if
// Valid/ready channels of the framed receiver: received bytes in, reply
// beats out.
// ----------------------------------------------------------------------------
interface xcfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfr_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;
	logic       connected;

	modport source (output valid, output tx_byte, output last_byte, output connected,
		input ready);
	modport sink   (input valid, input tx_byte, input last_byte, input connected,
		output ready);
endinterface

@@ design/xcfr_parser.sv @@
// ----------------------------------------------------------------------------
// xcfr_parser
// Frame parser state: start hunt, byte count, length and kind capture,
// running XOR and the sticky link flag. Advances one byte per step.
// ----------------------------------------------------------------------------
module xcfr_parser
	import xcfr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte_s1,
	output xcfr_status_t status
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic             in_frame_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [CNT_W-1:0] frame_length_q;
	logic [7:0]       frame_kind_q;
	logic [7:0]       running_xor_q;
	logic             link_up_q;

	logic [CNT_W-1:0] cnt_next;
	logic             is_len;
	logic             is_kind;
	logic             bad_len;
	logic             is_check;
	logic [7:0]       kind_eff;
	logic             reply_now;

	always_comb begin
		cnt_next  = byte_count_q + CNT_W'(1);
		is_len    = (cnt_next == CNT_W'(2));
		is_kind   = (cnt_next == CNT_W'(3));
		bad_len   = (rx_byte_s1 < MIN_FRAME_BYTES) ||
		            (rx_byte_s1 > 8'(MAX_FRAME_BYTES));
		is_check  = !is_len && (cnt_next >= CNT_W'(3)) && (cnt_next >= frame_length_q);
		kind_eff  = is_kind ? rx_byte_s1 : frame_kind_q;
		reply_now = in_frame_q && is_check && (rx_byte_s1 == running_xor_q) &&
		            (kind_eff == HANDSHAKE_KIND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			byte_count_q   <= '0;
			frame_length_q <= '0;
			frame_kind_q   <= '0;
			running_xor_q  <= '0;
			link_up_q      <= 1'b0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_byte_s1 == START_MARK) begin
					in_frame_q    <= 1'b1;
					byte_count_q  <= CNT_W'(1);
					running_xor_q <= START_MARK;
				end
			end else begin
				byte_count_q <= cnt_next;
				if (is_kind) begin
					frame_kind_q <= rx_byte_s1;
				end
				if (is_len) begin
					frame_length_q <= rx_byte_s1[CNT_W-1:0];
				end
				if (is_len && bad_len) begin
					in_frame_q   <= 1'b0;
					byte_count_q <= '0;
				end else if (is_check) begin
					// checksum byte: frame ends either way
					in_frame_q   <= 1'b0;
					byte_count_q <= '0;
					if (reply_now) begin
						link_up_q <= 1'b1;
					end
				end else begin
					running_xor_q <= running_xor_q ^ rx_byte_s1;
					if (cnt_next >= CNT_W'(MAX_FRAME_BYTES)) begin
						in_frame_q   <= 1'b0;
						byte_count_q <= '0;
					end
				end
			end
		end
	end

	assign status.reply   = reply_now;
	assign status.link_up = link_up_q;

endmodule

@@ design/xor_checked_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Parses start-marked, length-prefixed, XOR-checked frames from a byte
// stream and answers each good handshake frame with a two-beat reply.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle, sustained while the reply queue has room for a reply.
// Path: an accepted byte is held in the input register rx_byte_s1 and parsed
//   from there; the first reply beat is valid once the checksum byte has
//   passed through that register and the reply count pend_q.
// The reply queue holds four beats (two replies); a frame-closing byte that
//   needs a reply waits in the input register while more than two beats are queued.
// Reset (arst_n low): hunt for the start byte, link down, queue empty,
//   board_id back to 1.
module xor_checked_frame_receiver
	import xcfr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	xcfr_rx_if.sink               rx,
	xcfr_tx_if.source             tx,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// ---------------------------------------------------------------- config
	logic [7:0] board_id_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_id_q <= BOARD_ID_RESET;
		end else if (cfg_wr && (paddr[2] == REG_BOARD_ID)) begin
			board_id_q <= pwdata[7:0];
		end
	end

	// read back the register; holes read as zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BOARD_ID) begin
			prdata = {24'd0, board_id_q};
		end
	end

	// ---------------------------------------------------------- input stage
	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         advance;
	logic         room;
	xcfr_status_t status;
	logic [PEND_W-1:0] pend_q;
	logic              phase_q;   // 0: start-marker beat next, 1: board id beat

	// a reply needs two free queue slots; other bytes never wait
	assign room    = (pend_q <= PEND_W'(PEND_MAX - REPLY_BEATS));
	assign advance = valid_s1 && (!status.reply || room);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// payload: load on accept only
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	xcfr_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte_s1 (rx_byte_s1),
		.status     (status)
	);

	// ---------------------------------------------------------- reply queue
	// Every reply is the same two beats, so the queue is only a beat count
	// and a phase bit. The user must change board_id only while the block is
	// idle (the block itself does not enforce this), so the live register is sent.
	logic push;
	logic pop;

	assign push = advance && status.reply;
	assign pop  = tx.valid && tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			pend_q <= pend_q + (push ? PEND_W'(REPLY_BEATS) : PEND_W'(0))
			                 - (pop ? PEND_W'(1) : PEND_W'(0));
			if (pop) begin
				phase_q <= !phase_q;
			end
		end
	end

	assign tx.valid     = (pend_q != '0);
	assign tx.tx_byte   = phase_q ? board_id_q : START_MARK;
	assign tx.last_byte = phase_q;
	assign tx.connected = status.link_up;

	// ------------------------------------------------------------ checks
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(PEND_MAX))
		else $error("reply queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("reply pushed without room");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> tx.valid)
		else $error("reply not presented after push");

	a_beat_linked: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> status.link_up)
		else $error("reply beat while link down");

	a_phase_at_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == '0) |-> !phase_q)
		else $error("reply phase out of step with queue");

endmodule
